[sv/assert_macros.svh]
// Assertion macros for the semaphore RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define PWS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define PWS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/pws_pkg.sv]
// Types and constants of the priority wait semaphore.
package pws_pkg;

   localparam int BITS_PER_GROUP = 16;
   localparam int BIT_IDX_W      = $clog2(BITS_PER_GROUP);
   localparam int ACTION_W       = 3;
   localparam int STATUS_W       = 3;
   localparam int PRIO_W         = 6;
   localparam int CODE_W         = 8;
   localparam int COUNT_W        = 16;
   localparam int CSR_INDEX_W    = 4;

   // Actions
   localparam logic [ACTION_W-1:0] ACT_WAIT    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_CHECK   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DELETE  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CREATE  = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_AVAIL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_CFG   = 3'd4;

   // Code handed to waiters woken by a flushing delete
   localparam logic [CODE_W-1:0] CODE_INVALID = 8'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_INITIAL_COUNT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_COUNT     = 4'd1;

   // Most urgent waiter found by the picker
   typedef struct packed {
      logic              found;
      logic [PRIO_W-1:0] prio;
   } pick_type;

endpackage

[sv/pws_pick.sv]
// Picks the most urgent waiter from the two-level bitmap and the bitmap without it.
module pws_pick #(
   parameter int PRIORITY_GROUPS = 4
) (
   input  logic [PRIORITY_GROUPS-1:0]                              group_mask,
   input  logic [PRIORITY_GROUPS-1:0][pws_pkg::BITS_PER_GROUP-1:0] waiter_masks,
   output pws_pkg::pick_type                                       pick,
   output logic [PRIORITY_GROUPS-1:0][pws_pkg::BITS_PER_GROUP-1:0] rest_masks,
   output logic [PRIORITY_GROUPS-1:0]                              rest_group
);
   import pws_pkg::*;

   logic [PRIORITY_GROUPS-1:0]    grp_onehot;
   logic [BITS_PER_GROUP-1:0]     sel_mask;
   logic [BITS_PER_GROUP-1:0]     bit_onehot;
   logic [BIT_IDX_W-1:0]          bit_idx;
   logic [PRIO_W-BIT_IDX_W-1:0]   grp_idx;

   // Lowest set group, then lowest set bit in that group
   always_comb begin
      grp_onehot = group_mask & (~group_mask + PRIORITY_GROUPS'(1));
      sel_mask   = '0;
      grp_idx    = '0;
      for (int g = 0; g < PRIORITY_GROUPS; g++) begin
         if (grp_onehot[g]) begin
            sel_mask = sel_mask | waiter_masks[g];
            grp_idx  = grp_idx | (PRIO_W-BIT_IDX_W)'(g);
         end
      end
      bit_onehot = sel_mask & (~sel_mask + BITS_PER_GROUP'(1));
      bit_idx    = '0;
      for (int b = 0; b < BITS_PER_GROUP; b++) begin
         if (bit_onehot[b]) begin
            bit_idx = bit_idx | BIT_IDX_W'(b);
         end
      end
   end

   // Bitmap with the picked waiter removed
   always_comb begin
      for (int g = 0; g < PRIORITY_GROUPS; g++) begin
         rest_masks[g] = waiter_masks[g] & ~(grp_onehot[g] ? bit_onehot : '0);
         rest_group[g] = |rest_masks[g];
      end
   end

   assign pick.found = |group_mask;
   assign pick.prio  = {grp_idx, bit_idx};

endmodule

[sv/priority_wait_semaphore_unit.sv]
// Top level of the priority wait semaphore: command port, register stage, state and results.
//
// Each transaction is registered at acceptance and worked in the following cycle; its
// result is registered again before it strobes, and a new transaction can be taken in
// every cycle while busy is low. Results cannot be held off by the receiver. A delete with
// flush raises busy from the cycle after it is taken and then gives one result per queued
// waiter, one per cycle, most urgent first (a single result if none is queued or the
// semaphore is dead); busy drops with the cycle that carries the final result. The search
// for the lowest waiter over the group and bit masks is a single combinational picker between
// the state registers and the result register. Configuration writes are always accepted.
module priority_wait_semaphore_unit #(
   parameter int PRIORITY_GROUPS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // command transaction
   input  logic                                start,
   output logic                                busy,
   input  logic [pws_pkg::ACTION_W-1:0]        req_action,
   input  logic [pws_pkg::PRIO_W-1:0]          req_priority_req,
   input  logic [pws_pkg::CODE_W-1:0]          req_release_code,
   input  logic                                req_flush,
   // result transaction
   output logic                                rsp_strobe,
   output logic [pws_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_woke_valid,
   output logic [pws_pkg::PRIO_W-1:0]          rsp_woke_priority,
   output logic [pws_pkg::CODE_W-1:0]          rsp_woke_code,
   output logic                                rsp_preempt,
   output logic                                rsp_last,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pws_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pws_pkg::COUNT_W-1:0]         csr_data
);
   import pws_pkg::*;

   `include "assert_macros.svh"

   localparam int GRP_CMP_W = 5;

   // registers
   logic [COUNT_W-1:0] init_count_ff;
   logic [COUNT_W-1:0] max_count_ff;

   logic                pend_valid_ff;
   logic [ACTION_W-1:0] pend_action_ff;
   logic [PRIO_W-1:0]   pend_prio_ff;
   logic [CODE_W-1:0]   pend_code_ff;
   logic                pend_flush_ff;

   logic              drain_ff,      drain_in;
   logic [PRIO_W-1:0] drain_prio_ff, drain_prio_in;

   logic [COUNT_W-1:0]         count_ff,      count_in;
   logic                       alive_ff,      alive_in;
   logic [PRIORITY_GROUPS-1:0] group_mask_ff, group_mask_in;
   logic [PRIORITY_GROUPS-1:0][BITS_PER_GROUP-1:0] waiter_ff, waiter_in;

   logic                rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_wvalid_ff, rsp_wvalid_in;
   logic [PRIO_W-1:0]   rsp_wprio_ff,  rsp_wprio_in;
   logic [CODE_W-1:0]   rsp_wcode_ff,  rsp_wcode_in;
   logic                rsp_pre_ff,    rsp_pre_in;
   logic                rsp_last_ff,   rsp_last_in;

   // picker outputs
   pick_type                                       pick;
   logic [PRIORITY_GROUPS-1:0][BITS_PER_GROUP-1:0] rest_masks;
   logic [PRIORITY_GROUPS-1:0]                     rest_group;

   logic accept;
   logic pend_group_ok;

   pws_pick #(
      .PRIORITY_GROUPS(PRIORITY_GROUPS)
   ) u_pick (
      .group_mask  (group_mask_ff),
      .waiter_masks(waiter_ff),
      .pick        (pick),
      .rest_masks  (rest_masks),
      .rest_group  (rest_group)
   );

   // handshakes
   assign busy      = drain_ff |
                      (pend_valid_ff & (pend_action_ff == ACT_DELETE) & pend_flush_ff);
   assign accept    = start & ~busy;
   assign csr_ready = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         init_count_ff <= COUNT_W'(1);
         max_count_ff  <= COUNT_W'(1);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_INITIAL_COUNT) begin
            init_count_ff <= csr_data;
         end
         if (csr_index == REG_MAX_COUNT) begin
            max_count_ff <= csr_data;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= accept;
      end
      if (accept) begin
         pend_action_ff <= req_action;
         pend_prio_ff   <= req_priority_req;
         pend_code_ff   <= req_release_code;
         pend_flush_ff  <= req_flush;
      end
   end

   // caller's group exists in the bitmap
   assign pend_group_ok = {3'b000, pend_prio_ff[PRIO_W-1:PRIO_W-2]} <
                          GRP_CMP_W'(PRIORITY_GROUPS);

   // semaphore state update and result
   always_comb begin
      count_in      = count_ff;
      alive_in      = alive_ff;
      group_mask_in = group_mask_ff;
      waiter_in     = waiter_ff;
      drain_in      = drain_ff;
      drain_prio_in = drain_prio_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_wvalid_in = 1'b0;
      rsp_wprio_in  = '0;
      rsp_wcode_in  = '0;
      rsp_pre_in    = 1'b0;
      rsp_last_in   = 1'b1;

      if (drain_ff) begin
         // flushing delete: wake one waiter per cycle
         rsp_valid_in  = 1'b1;
         rsp_wvalid_in = 1'b1;
         rsp_wprio_in  = pick.prio;
         rsp_wcode_in  = CODE_INVALID;
         rsp_pre_in    = pick.prio < drain_prio_ff;
         rsp_last_in   = rest_group == '0;
         waiter_in     = rest_masks;
         group_mask_in = rest_group;
         drain_in      = rest_group != '0;
      end else if (pend_valid_ff) begin
         rsp_valid_in = 1'b1;
         if (pend_action_ff == ACT_CREATE) begin
            group_mask_in = '0;
            waiter_in     = '0;
            if (init_count_ff > max_count_ff) begin
               alive_in      = 1'b0;
               rsp_status_in = ST_BAD_CFG;
            end else begin
               alive_in = 1'b1;
               count_in = init_count_ff;
            end
         end else if (pend_action_ff > ACT_CREATE) begin
            rsp_status_in = ST_OK;
         end else if (!alive_ff) begin
            rsp_status_in = ST_INVALID;
         end else begin
            unique case (pend_action_ff)
               ACT_WAIT: begin
                  if (count_ff != '0) begin
                     count_in = count_ff - COUNT_W'(1);
                  end else if (pend_group_ok) begin
                     for (int g = 0; g < PRIORITY_GROUPS; g++) begin
                        if ({3'b000, pend_prio_ff[PRIO_W-1:PRIO_W-2]} == GRP_CMP_W'(g)) begin
                           waiter_in[g][pend_prio_ff[BIT_IDX_W-1:0]] = 1'b1;
                           group_mask_in[g] = 1'b1;
                        end
                     end
                     rsp_status_in = ST_QUEUED;
                  end else begin
                     rsp_status_in = ST_NOT_AVAIL;
                  end
               end
               ACT_CHECK: begin
                  if (count_ff != '0) begin
                     count_in = count_ff - COUNT_W'(1);
                  end else begin
                     rsp_status_in = ST_NOT_AVAIL;
                  end
               end
               ACT_RELEASE: begin
                  if (!pick.found) begin
                     if (count_ff < max_count_ff) begin
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end else begin
                     rsp_wvalid_in = 1'b1;
                     rsp_wprio_in  = pick.prio;
                     rsp_wcode_in  = pend_code_ff;
                     rsp_pre_in    = pick.prio < pend_prio_ff;
                     waiter_in     = rest_masks;
                     group_mask_in = rest_group;
                  end
               end
               ACT_DELETE: begin
                  alive_in = 1'b0;
                  if (pend_flush_ff && pick.found) begin
                     rsp_wvalid_in = 1'b1;
                     rsp_wprio_in  = pick.prio;
                     rsp_wcode_in  = CODE_INVALID;
                     rsp_pre_in    = pick.prio < pend_prio_ff;
                     rsp_last_in   = rest_group == '0;
                     waiter_in     = rest_masks;
                     group_mask_in = rest_group;
                     drain_in      = rest_group != '0;
                     drain_prio_in = pend_prio_ff;
                  end else begin
                     waiter_in     = '0;
                     group_mask_in = '0;
                  end
               end
               default: begin
                  rsp_status_in = ST_OK;
               end
            endcase
         end
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= COUNT_W'(1);
         alive_ff      <= 1'b1;
         group_mask_ff <= '0;
         waiter_ff     <= '0;
         drain_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         alive_ff      <= alive_in;
         group_mask_ff <= group_mask_in;
         waiter_ff     <= waiter_in;
         drain_ff      <= drain_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      drain_prio_ff <= drain_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_wvalid_ff <= rsp_wvalid_in;
      rsp_wprio_ff  <= rsp_wprio_in;
      rsp_wcode_ff  <= rsp_wcode_in;
      rsp_pre_ff    <= rsp_pre_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_woke_valid    = rsp_wvalid_ff;
   assign rsp_woke_priority = rsp_wprio_ff;
   assign rsp_woke_code     = rsp_wcode_ff;
   assign rsp_preempt       = rsp_pre_ff;
   assign rsp_last          = rsp_last_ff;

   // checks
   `PWS_ASSERT_IMP(a_strobe_src, rsp_strobe, $past(pend_valid_ff || drain_ff), "stray result")
   `PWS_ASSERT_IMP(a_drain_has_waiter, drain_ff, group_mask_ff != '0, "flush with no waiter left")
   `PWS_ASSERT_IMP(a_drain_dead, drain_ff, !alive_ff, "flush on a live semaphore")
   `PWS_ASSERT_NXT(a_flush_back_to_back, rsp_strobe && !rsp_last, rsp_strobe, "gap in flush")

endmodule

[tb/pws_checker.sv]
// Checker for the priority wait semaphore: predicts each command's results and compares them.
`timescale 1ns / 1ps

module pws_checker #(
   parameter int GROUPS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // command transaction
   input  logic                                start,
   input  logic                                busy,
   input  logic [pws_pkg::ACTION_W-1:0]        req_action,
   input  logic [pws_pkg::PRIO_W-1:0]          req_priority_req,
   input  logic [pws_pkg::CODE_W-1:0]          req_release_code,
   input  logic                                req_flush,
   // result transaction
   input  logic                                rsp_strobe,
   input  logic [pws_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                rsp_woke_valid,
   input  logic [pws_pkg::PRIO_W-1:0]          rsp_woke_priority,
   input  logic [pws_pkg::CODE_W-1:0]          rsp_woke_code,
   input  logic                                rsp_preempt,
   input  logic                                rsp_last,
   // register writes
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [pws_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pws_pkg::COUNT_W-1:0]         csr_data,
   // totals for the top
   output int                                  mismatch_count,
   output int                                  pending_results,
   output int                                  results_checked
);
   import pws_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                woke_valid;
      logic [PRIO_W-1:0]   woke_prio;
      logic [CODE_W-1:0]   woke_code;
      logic                preempt;
      logic                last;
   } sem_result_type;

   // Register copies and semaphore state
   logic [COUNT_W-1:0]                  cfg_initial;
   logic [COUNT_W-1:0]                  cfg_max;
   logic [COUNT_W-1:0]                  sem_count;
   logic                                sem_alive;
   logic [GROUPS-1:0][BITS_PER_GROUP-1:0] waiter_masks;

   sem_result_type sem_results_due[$];
   sem_result_type due;

   function automatic logic any_waiter();
      return waiter_masks != '0;
   endfunction

   // Remove the most urgent waiter: lowest group first, then lowest bit in it
   function automatic logic [PRIO_W-1:0] pop_most_urgent();
      logic [PRIO_W-1:0] prio;
      logic              found;
      prio  = '0;
      found = 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
         for (int b = 0; b < BITS_PER_GROUP; b++) begin
            if (!found && waiter_masks[g][b]) begin
               found              = 1'b1;
               prio               = PRIO_W'(g * BITS_PER_GROUP + b);
               waiter_masks[g][b] = 1'b0;
            end
         end
      end
      return prio;
   endfunction

   // Work out the results of one accepted command and update the state
   function automatic void predict_semaphore_op(logic [ACTION_W-1:0] action,
                                                logic [PRIO_W-1:0] prio,
                                                logic [CODE_W-1:0] code,
                                                logic flush);
      sem_result_type r;
      int             grp;
      int             n;
      r      = '0;
      r.last = 1'b1;
      grp    = int'(prio) / BITS_PER_GROUP;
      n      = 0;
      if (action == ACT_CREATE) begin
         waiter_masks = '0;
         if (cfg_initial > cfg_max) begin
            sem_alive = 1'b0;
            r.status  = ST_BAD_CFG;
         end else begin
            sem_alive = 1'b1;
            sem_count = cfg_initial;
            r.status  = ST_OK;
         end
         sem_results_due.push_back(r);
      end else if (action > ACT_CREATE) begin
         // unknown action: plain ok, nothing changes
         sem_results_due.push_back(r);
      end else if (!sem_alive) begin
         r.status = ST_INVALID;
         sem_results_due.push_back(r);
      end else begin
         case (action) inside
            ACT_WAIT, ACT_CHECK: begin
               if (sem_count > 0) begin
                  sem_count = sem_count - 16'd1;
                  r.status  = ST_OK;
               end else if (action == ACT_WAIT && grp < GROUPS) begin
                  waiter_masks[grp][prio % BITS_PER_GROUP] = 1'b1;
                  r.status = ST_QUEUED;
               end else begin
                  r.status = ST_NOT_AVAIL;
               end
               sem_results_due.push_back(r);
            end
            ACT_RELEASE: begin
               if (!any_waiter()) begin
                  if (sem_count < cfg_max)
                     sem_count = sem_count + 16'd1;
               end else begin
                  r.woke_valid = 1'b1;
                  r.woke_prio  = pop_most_urgent();
                  r.woke_code  = code;
                  r.preempt    = r.woke_prio < prio;
               end
               sem_results_due.push_back(r);
            end
            default: begin
               // delete; a flush wakes every waiter in priority order
               if (flush) begin
                  while (any_waiter()) begin
                     r.woke_valid = 1'b1;
                     r.woke_prio  = pop_most_urgent();
                     r.woke_code  = CODE_INVALID;
                     r.preempt    = r.woke_prio < prio;
                     r.last       = !any_waiter();
                     sem_results_due.push_back(r);
                     n++;
                  end
               end
               waiter_masks = '0;
               sem_alive    = 1'b0;
               if (n == 0) begin
                  r = '0;
                  r.last = 1'b1;
                  sem_results_due.push_back(r);
               end
            end
         endcase
      end
   endfunction

   function automatic void compare_field(string field_name, int unsigned want,
                                         int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field_name, want, got);
         mismatch_count++;
      end
   endfunction

   // Watch the three channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         cfg_initial     = 16'd1;
         cfg_max         = 16'd1;
         sem_count       = 16'd1;
         sem_alive       = 1'b1;
         waiter_masks    = '0;
         sem_results_due.delete();
         mismatch_count  = 0;
         results_checked = 0;
      end else begin
         if (rsp_strobe) begin
            if (sem_results_due.size() == 0) begin
               $display("%0t: unexpected result, status %0d woke %0d prio %0d last %0d",
                        $time, rsp_status, rsp_woke_valid, rsp_woke_priority, rsp_last);
               mismatch_count++;
            end else begin
               due = sem_results_due.pop_front();
               compare_field("status", due.status, rsp_status);
               compare_field("woke_valid", due.woke_valid, rsp_woke_valid);
               compare_field("woke_priority", due.woke_prio, rsp_woke_priority);
               compare_field("woke_code", due.woke_code, rsp_woke_code);
               compare_field("preempt", due.preempt, rsp_preempt);
               compare_field("last", due.last, rsp_last);
               results_checked++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_INITIAL_COUNT: cfg_initial = csr_data;
               REG_MAX_COUNT:     cfg_max     = csr_data;
               default: ;
            endcase
         end
         if (start && !busy)
            predict_semaphore_op(req_action, req_priority_req, req_release_code, req_flush);
      end
      pending_results <= sem_results_due.size();
   end

endmodule

[tb/tb_priority_wait_semaphore_unit.sv]
// Testbench top for the priority wait semaphore: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_priority_wait_semaphore_unit;
   import pws_pkg::*;

   localparam int GROUPS         = 4;
   localparam int NUM_PHASES     = 7;
   localparam int ITEMS_PER_PHASE = 22;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int NO_IDLE_PHASE  = 3;
   // index that maps to no register; writes to it must be ignored
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 4'hF;
   // action codes above create are not defined
   localparam logic [ACTION_W-1:0] ACT_UNKNOWN_LO = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_UNKNOWN_HI = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [ACTION_W-1:0]    req_action;
   logic [PRIO_W-1:0]      req_priority_req;
   logic [CODE_W-1:0]      req_release_code;
   logic                   req_flush;
   logic                   rsp_strobe;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   rsp_woke_valid;
   logic [PRIO_W-1:0]      rsp_woke_priority;
   logic [CODE_W-1:0]      rsp_woke_code;
   logic                   rsp_preempt;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COUNT_W-1:0]     csr_data;

   int mismatch_count;
   int pending_results;
   int results_checked;
   int commands_sent;
   int stall_cycles;
   bit idle_on;

   priority_wait_semaphore_unit #(.PRIORITY_GROUPS(GROUPS)) dut (.*);

   pws_checker #(.GROUPS(GROUPS)) sem_check (.*);

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Watchdog: ends the run when no transaction of any kind moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_results);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Pick one of the undefined action codes from the random draw
   function automatic logic [ACTION_W-1:0] ACT_ACTION_UNKNOWN(int pick);
      return ACT_UNKNOWN_LO + ACTION_W'(pick % 3);
   endfunction

   // Present one command and hold it until taken; start stays high afterwards
   task automatic send_cmd(logic [ACTION_W-1:0] action, logic [PRIO_W-1:0] prio,
                           logic [CODE_W-1:0] code, logic flush);
      start            <= 1'b1;
      req_action       <= action;
      req_priority_req <= prio;
      req_release_code <= code;
      req_flush        <= flush;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      commands_sent++;
   endtask

   // Random idle cycles between commands
   task automatic pace();
      if (idle_on && $urandom_range(99) < 21) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 2))
            @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [COUNT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // Stop issuing and wait until every predicted result has come back
   task automatic drain();
      start <= 1'b0;
      do
         @(negedge clock);
      while (pending_results != 0);
      @(posedge clock);
   endtask

   task automatic directed_cmd(logic [ACTION_W-1:0] action, logic [PRIO_W-1:0] prio,
                               logic [CODE_W-1:0] code, logic flush);
      pace();
      send_cmd(action, prio, code, flush);
   endtask

   initial begin
      logic [COUNT_W-1:0]  init_value;
      logic [COUNT_W-1:0]  max_value;
      logic [ACTION_W-1:0] action;
      int                  pick;

      commands_sent = 0;
      idle_on       = 1'b1;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_action       <= ACT_WAIT;
      req_priority_req <= '0;
      req_release_code <= '0;
      req_flush        <= 1'b0;
      csr_valid        <= 1'b0;
      csr_index        <= REG_INITIAL_COUNT;
      csr_data         <= '0;
      repeat (5)
         @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset settings (count 1, max 1)
      directed_cmd(ACT_WAIT,    6'd0,  8'd0,   1'b0);  // takes the only unit
      directed_cmd(ACT_CHECK,   6'd63, 8'd255, 1'b1);  // try with zero count
      directed_cmd(ACT_WAIT,    6'd63, 8'd0,   1'b0);  // queue least urgent
      directed_cmd(ACT_WAIT,    6'd5,  8'd0,   1'b0);
      directed_cmd(ACT_WAIT,    6'd40, 8'd0,   1'b0);
      directed_cmd(ACT_WAIT,    6'd17, 8'd0,   1'b0);
      directed_cmd(ACT_WAIT,    6'd5,  8'd0,   1'b0);  // already queued
      directed_cmd(ACT_RELEASE, 6'd10, 8'd255, 1'b0);  // wakes 5 with preemption
      directed_cmd(ACT_RELEASE, 6'd0,  8'd0,   1'b0);  // wakes 17, no preemption
      directed_cmd(ACT_DELETE,  6'd63, 8'd0,   1'b1);  // flush of 40 and 63
      directed_cmd(ACT_WAIT,    6'd1,  8'd0,   1'b0);  // dead semaphore
      directed_cmd(ACT_CHECK,   6'd1,  8'd0,   1'b0);
      directed_cmd(ACT_RELEASE, 6'd1,  8'd9,   1'b0);
      directed_cmd(ACT_DELETE,  6'd1,  8'd0,   1'b1);
      directed_cmd(ACT_UNKNOWN_LO, 6'd0, 8'd0, 1'b0);
      directed_cmd(ACT_UNKNOWN_HI, 6'd63, 8'd255, 1'b1);
      directed_cmd(ACT_CREATE,  6'd0,  8'd0,   1'b0);
      directed_cmd(ACT_RELEASE, 6'd0,  8'd0,   1'b0);  // count already at max
      directed_cmd(ACT_CHECK,   6'd0,  8'd0,   1'b0);
      directed_cmd(ACT_RELEASE, 6'd0,  8'd170, 1'b0);  // no waiters, count back up
      directed_cmd(ACT_WAIT,    6'd48, 8'd0,   1'b0);
      directed_cmd(ACT_WAIT,    6'd0,  8'd0,   1'b0);
      directed_cmd(ACT_WAIT,    6'd15, 8'd0,   1'b0);
      directed_cmd(ACT_DELETE,  6'd0,  8'd0,   1'b0);  // no flush: waiters dropped
      directed_cmd(ACT_CREATE,  6'd0,  8'd0,   1'b0);

      // Random phases, each on its own register setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       begin init_value = 16'd0;     max_value = 16'd0;     end
            1:       begin init_value = 16'd2;     max_value = 16'd4;     end
            2:       begin init_value = 16'hFFFF;  max_value = 16'hFFFF;  end
            3:       begin init_value = 16'd0;     max_value = 16'hFFFF;  end
            4:       begin init_value = 16'hFFFF;  max_value = 16'd0;     end
            5:       begin init_value = 16'd3;     max_value = 16'd3;     end
            default: begin init_value = 16'd1;     max_value = 16'd1;     end
         endcase
         drain();
         csr_write(REG_INITIAL_COUNT, init_value);
         csr_write(REG_MAX_COUNT, max_value);
         if (p == 0)
            csr_write(REG_UNUSED, 16'hFFFF);
         csr_valid <= 1'b0;
         idle_on = (p != NO_IDLE_PHASE);
         send_cmd(ACT_CREATE, PRIO_W'($urandom), CODE_W'($urandom), 1'($urandom));

         repeat (ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 36)
               action = ACT_WAIT;
            else if (pick < 46)
               action = ACT_CHECK;
            else if (pick < 76)
               action = ACT_RELEASE;
            else if (pick < 82)
               action = ACT_DELETE;
            else if (pick < 94)
               action = ACT_CREATE;
            else
               action = ACT_ACTION_UNKNOWN(pick);
            pace();
            send_cmd(action, PRIO_W'($urandom_range(63)), CODE_W'($urandom_range(255)),
                     1'($urandom));
         end
      end

      drain();
      repeat (5)
         @(posedge clock);

      $display("Ran %0d commands over %0d register settings; %0d results compared.",
               commands_sent, NUM_PHASES + 1, results_checked);
      $display("Covered queueing, releases with and without preemption, flushing deletes,");
      $display("dead-semaphore and bad-config cases, and undefined action codes.");
      if (mismatch_count == 0 && pending_results == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/pws_pkg.sv
sv/pws_pick.sv
sv/priority_wait_semaphore_unit.sv
tb/pws_checker.sv
tb/tb_priority_wait_semaphore_unit.sv
